[rtl/tlc_pkg.sv]
// Shared types and constants of the two-way LRU cache tag lookup.
// Depends on nothing; every other file of the block but tlc_ram uses it.
package tlc_pkg;

	localparam int ADDR_BITS = 32;
	localparam int CNT_BITS  = 32;

	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;

endpackage

[rtl/tlc_req_if.sv]
// Request channel of the tag lookup: one byte address per transfer.
// Depends on tlc_pkg for the address type.
interface tlc_req_if;

	logic          valid;
	logic          ready;
	tlc_pkg::addr_t address;

	modport source (output valid, output address, input ready);
	modport sink   (input valid, input address, output ready);

endinterface

[rtl/tlc_rsp_if.sv]
// Result channel of the tag lookup: one lookup outcome per transfer.
// Depends on tlc_pkg for the counter type; field widths follow the geometry.
interface tlc_rsp_if #(
	parameter int OFFSET_BITS = 5,
	parameter int SET_BITS    = 6
);

	localparam int BLOCK_BITS = tlc_pkg::ADDR_BITS - OFFSET_BITS;
	localparam int TAG_BITS   = BLOCK_BITS - SET_BITS;

	logic                  valid;
	logic                  ready;
	logic                  is_miss;
	logic                  way;
	logic [SET_BITS-1:0]   set_index;
	logic [OFFSET_BITS-1:0] byte_offset;
	logic [BLOCK_BITS-1:0] block_number;
	logic [TAG_BITS-1:0]   line_tag;
	logic                  replaced_valid;
	logic [TAG_BITS-1:0]   evicted_tag;
	tlc_pkg::cnt_t         hit_total;
	tlc_pkg::cnt_t         miss_total;

	modport source (
		output valid, output is_miss, output way, output set_index, output byte_offset,
		output block_number, output line_tag, output replaced_valid, output evicted_tag,
		output hit_total, output miss_total, input ready
	);
	modport sink (
		input valid, input is_miss, input way, input set_index, input byte_offset,
		input block_number, input line_tag, input replaced_valid, input evicted_tag,
		input hit_total, input miss_total, output ready
	);

endinterface

[rtl/two_way_lru_cache_tag_lookup_top.sv]
// Top level of the two-way LRU cache tag lookup.
// Depends on tlc_pkg, tlc_req_if, tlc_rsp_if and tlc_ram.
//
// Usage:
//   Each transfer on req carries one byte address. The block splits it into
//   byte offset, set index and tag, reads both ways of the set from one RAM
//   word and returns one transfer on rsp with hit or miss, the way used, any
//   evicted tag and the running hit and miss counts.
//   Throughput: one request per cycle while no clearing pass runs and rsp
//   takes each result. Each set lives in a single RAM word (both tags, both
//   valid bits and the LRU bit), read in the cycle of the transfer and written
//   back when the lookup moves on to the output register; a write-back is
//   forwarded to a lookup of the same set that follows directly.
//   Reset: after arst_n is released a clearing pass writes zero to every set,
//   during which req.ready stays low.
//   Stall: a result waits in the output register while rsp.ready is low; one
//   more request can be taken meanwhile and then req.ready drops.
//   NUM_SETS must be a power of two.
module two_way_lru_cache_tag_lookup_top #(
	parameter int NUM_SETS    = 64,
	parameter int OFFSET_BITS = 5
) (
	input  logic clk,
	input  logic arst_n,
	tlc_req_if.sink   req,
	tlc_rsp_if.source rsp
);

	import tlc_pkg::*;

	localparam int SET_BITS   = $clog2(NUM_SETS);
	localparam int BLOCK_BITS = ADDR_BITS - OFFSET_BITS;
	localparam int TAG_BITS   = BLOCK_BITS - SET_BITS;
	// RAM word: {lru, valid1, valid0, tag1, tag0}
	localparam int V0_POS     = 2 * TAG_BITS;
	localparam int V1_POS     = V0_POS + 1;
	localparam int LRU_POS    = V0_POS + 2;
	localparam int WORD_BITS  = LRU_POS + 1;

	typedef logic [SET_BITS-1:0]  set_t;
	typedef logic [TAG_BITS-1:0]  tag_t;
	typedef logic [WORD_BITS-1:0] word_t;

	// Clearing pass
	logic clearing_q;
	set_t clr_idx_q;

	// Lookup stage
	logic  valid_s1;
	addr_t addr_s1;

	// Forwarding of the last write-back
	logic  fwd_valid_q;
	set_t  fwd_set_q;
	word_t fwd_word_q;

	// Counters and output register
	cnt_t hit_q;
	cnt_t miss_q;
	logic rsp_valid_q;

	logic  in_fire;
	logic  s1_go;
	set_t  req_set;
	set_t  set_s1;
	tag_t  tag_s1;
	word_t rd_word;
	word_t cur_word;
	word_t new_word;
	tag_t  tag0, tag1;
	logic  v0, v1, lru;
	logic  hit0, hit1, miss;
	logic  way_sel;
	logic  repl;
	tag_t  evicted;
	cnt_t  hit_n, miss_n;

	logic  ram_we;
	set_t  ram_waddr;
	word_t ram_wdata;
	set_t  ram_raddr;

	assign req_set = req.address[OFFSET_BITS +: SET_BITS];
	assign set_s1  = addr_s1[OFFSET_BITS +: SET_BITS];
	assign tag_s1  = addr_s1[OFFSET_BITS + SET_BITS +: TAG_BITS];

	assign s1_go     = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !clearing_q && (!valid_s1 || s1_go);
	assign in_fire   = req.valid && req.ready;

	// While a lookup is held, its set is read again so the data stays current.
	assign ram_raddr = in_fire ? req_set : set_s1;

	tlc_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(NUM_SETS)
	) u_tag_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rd_word)
	);

	// The word written in the previous cycle has not reached the read data yet.
	assign cur_word = (fwd_valid_q && (fwd_set_q == set_s1)) ? fwd_word_q : rd_word;

	assign tag0 = cur_word[0 +: TAG_BITS];
	assign tag1 = cur_word[TAG_BITS +: TAG_BITS];
	assign v0   = cur_word[V0_POS];
	assign v1   = cur_word[V1_POS];
	assign lru  = cur_word[LRU_POS];

	assign hit0    = v0 && (tag0 == tag_s1);
	assign hit1    = !hit0 && v1 && (tag1 == tag_s1);
	assign miss    = !hit0 && !hit1;
	assign way_sel = hit0 ? 1'b0 : (hit1 ? 1'b1 : lru);
	assign repl    = miss && (way_sel ? v1 : v0);
	assign evicted = repl ? (way_sel ? tag1 : tag0) : '0;

	assign hit_n  = hit_q + cnt_t'(!miss);
	assign miss_n = miss_q + cnt_t'(miss);

	always_comb begin
		new_word = cur_word;
		// Whether it hit or was filled, the used way becomes most recent.
		new_word[LRU_POS] = !way_sel;
		if (miss) begin
			if (way_sel) begin
				new_word[TAG_BITS +: TAG_BITS] = tag_s1;
				new_word[V1_POS] = 1'b1;
			end else begin
				new_word[0 +: TAG_BITS] = tag_s1;
				new_word[V0_POS] = 1'b1;
			end
		end
	end

	assign ram_we    = clearing_q || s1_go;
	assign ram_waddr = clearing_q ? clr_idx_q : set_s1;
	assign ram_wdata = clearing_q ? '0 : new_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_idx_q   <= '0;
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
			hit_q       <= '0;
			miss_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + set_t'(1);
				if (clr_idx_q == set_t'(NUM_SETS - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			fwd_valid_q <= s1_go;
			if (s1_go) begin
				hit_q       <= hit_n;
				miss_q      <= miss_n;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			addr_s1 <= req.address;
		end
		if (s1_go) begin
			fwd_set_q          <= set_s1;
			fwd_word_q         <= new_word;
			rsp.is_miss        <= miss;
			rsp.way            <= way_sel;
			rsp.set_index      <= set_s1;
			rsp.byte_offset    <= addr_s1[OFFSET_BITS-1:0];
			rsp.block_number   <= addr_s1[ADDR_BITS-1:OFFSET_BITS];
			rsp.line_tag       <= tag_s1;
			rsp.replaced_valid <= repl;
			rsp.evicted_tag    <= evicted;
			rsp.hit_total      <= hit_n;
			rsp.miss_total     <= miss_n;
		end
	end

	assign rsp.valid = rsp_valid_q;

endmodule

[rtl/tlc_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module tlc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
